// ===== hdl/stream_transport_server_engine_unit_macros.svh =====
// assertion macros shared by the transport server engine rtl
// no dependencies; define ASSERT_OFF to compile the checks away
`ifndef STREAM_TRANSPORT_SERVER_ENGINE_UNIT_MACROS_SVH
`define STREAM_TRANSPORT_SERVER_ENGINE_UNIT_MACROS_SVH

`ifndef ASSERT_OFF

// clocked check, off while reset is held
`define STSE_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked check that also holds during reset
`define STSE_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define STSE_ASSERT(lbl, clk, rst_n, prop, msg)
`define STSE_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

// ===== hdl/stse_pkg.sv =====
`timescale 1ns / 1ps
// types, codes and sizing constants of the transport server engine
// no dependencies; used by the interfaces, the table and the top level
package stse_pkg;

    // sizing
    localparam int CONNECTIONS    = 16;
    localparam int RECV_BUF_BYTES = 4096;
    localparam int MAX_SEG_BYTES  = 1500;

    localparam int IDX_W = (CONNECTIONS > 1) ? $clog2(CONNECTIONS) : 1;
    localparam int BUF_W = $clog2(RECV_BUF_BYTES + 1);
    localparam int SUM_W = ((BUF_W > 11) ? BUF_W : 11) + 1;

    typedef logic [IDX_W-1:0] t_idx;
    localparam t_idx IDX_LAST = t_idx'(CONNECTIONS - 1);

    // configuration register indexes
    typedef logic [0:0] t_cfg_idx;
    localparam t_cfg_idx CFG_MY_NODE_ID      = 1'b0;
    localparam t_cfg_idx CFG_CLOSEWAIT_TICKS = 1'b1;
    localparam logic [31:0] CW_TICKS_RESET   = 32'd1000;

    // peer node not yet known
    localparam logic [8:0] NODE_UNKNOWN = 9'h100;

    typedef enum logic [2:0] {
        FN_SEGMENT = 3'd0,
        FN_OPEN    = 3'd1,
        FN_LISTEN  = 3'd2,
        FN_READ    = 3'd3,
        FN_CLOSE   = 3'd4,
        FN_TICK    = 3'd5
    } t_func;

    typedef enum logic [2:0] {
        SK_SYN     = 3'd0,
        SK_SYNACK  = 3'd1,
        SK_FIN     = 3'd2,
        SK_FINACK  = 3'd3,
        SK_DATA    = 3'd4,
        SK_DATAACK = 3'd5
    } t_seg_kind;

    typedef enum logic [2:0] {
        STS_OK          = 3'd0,
        STS_NO_FREE     = 3'd1,
        STS_NOT_IN_USE  = 3'd2,
        STS_NOT_READY   = 3'd3,
        STS_DROPPED     = 3'd4,
        STS_OUT_OF_SEQ  = 3'd5,
        STS_BUFFER_FULL = 3'd6
    } t_status;

    typedef enum logic [1:0] {
        CS_CLOSED = 2'd0,
        CS_LISTEN = 2'd1,
        CS_CONN   = 2'd2,
        CS_CWAIT  = 2'd3
    } t_conn_state;

    typedef enum logic [1:0] {
        S_IDLE = 2'd0,
        S_SCAN = 2'd1,
        S_EXEC = 2'd2
    } t_fsm;

    // one connection table entry
    typedef struct packed {
        logic              used;
        t_conn_state       state;
        logic [15:0]       bound_port;
        logic [15:0]       peer_port;
        logic [8:0]        peer_node;
        logic [31:0]       expected_seq;
        logic [BUF_W-1:0]  buffered;
    } t_entry;

    localparam t_entry ENTRY_RESET = '{
        used:         1'b0,
        state:        CS_CLOSED,
        bound_port:   16'd0,
        peer_port:    16'd0,
        peer_node:    NODE_UNKNOWN,
        expected_seq: 32'd0,
        buffered:     '0
    };

    // input transfer payload
    typedef struct packed {
        logic [2:0]  func;
        logic [2:0]  seg_kind;
        logic [7:0]  src_node;
        logic [15:0] sender_port;
        logic [15:0] target_port;
        logic [31:0] seq_number;
        logic [10:0] seg_length;
        logic [3:0]  socket_id;
        logic [15:0] local_port;
        logic [12:0] read_length;
    } t_in_item;

    // result transfer payload
    typedef struct packed {
        logic [2:0]  status;
        logic        reply_valid;
        logic [2:0]  reply_kind;
        logic [15:0] reply_src_port;
        logic [15:0] reply_dest_port;
        logic [7:0]  reply_node;
        logic [31:0] ack_number;
        logic [3:0]  result_socket;
        logic [1:0]  conn_state_out;
    } t_out_item;

endpackage

// ===== hdl/stse_in_if.sv =====
`timescale 1ns / 1ps
// valid/ready channel carrying host operations, segments and ticks
// depends on stse_pkg for the payload type
interface stse_in_if;
    import stse_pkg::*;

    logic     valid;
    logic     ready;
    t_in_item item;

    modport source (output valid, output item, input ready);
    modport sink   (input valid, input item, output ready);
endinterface

// ===== hdl/stse_out_if.sv =====
`timescale 1ns / 1ps
// valid/ready channel carrying one result per input transfer
// depends on stse_pkg for the payload type
interface stse_out_if;
    import stse_pkg::*;

    logic      valid;
    logic      ready;
    t_out_item item;

    modport source (output valid, output item, input ready);
    modport sink   (input valid, input item, output ready);
endinterface

// ===== hdl/stse_conn_table.sv =====
`timescale 1ns / 1ps
// connection table: one entry per connection, read and written at one index
// depends on stse_pkg for the entry type and table size
module stse_conn_table (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  stse_pkg::t_idx   i_addr,
    input  logic            i_wr_en,
    input  stse_pkg::t_entry i_wr_entry,
    output stse_pkg::t_entry o_rd_entry
);
    import stse_pkg::*;

    t_entry r_table [CONNECTIONS];

    // entry storage, all entries closed and unused after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < CONNECTIONS; k++) begin
                r_table[k] <= ENTRY_RESET;
            end
        end else if (i_wr_en) begin
            r_table[i_addr] <= i_wr_entry;
        end
    end

    // single read port at the current index
    assign o_rd_entry = r_table[i_addr];

endmodule

// ===== hdl/stream_transport_server_engine_unit.sv =====
`timescale 1ns / 1ps
// Server side of a simplified stream transport with a table of connections.
// Each input transfer (segment, open, listen, read, close or tick) yields
// exactly one result transfer. One item is handled at a time: the input is
// ready only between items. Listen, read, close, tick, unused codes and a
// segment to port 0 go from acceptance straight to the execute step. A
// segment or an open walks the connection table one entry per cycle through
// a single port/free comparator, stopping at the first match or after the
// last entry, before the execute step. The input is ready again as soon as
// the result is loaded. The result sits in an output register; the next item
// can be accepted while it waits to be taken, but its own result waits for
// that register to drain. Configuration writes take effect at once; the node
// id register affects no output and is accepted and discarded.
// Depends on stse_pkg, stse_in_if, stse_out_if, stse_conn_table and the
// macros header.
`include "stream_transport_server_engine_unit_macros.svh"

module stream_transport_server_engine_unit (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_wr_en,
    input  stse_pkg::t_cfg_idx  i_cfg_index,
    input  logic [31:0]         i_cfg_data,
    stse_in_if.sink             i_in,
    stse_out_if.source          o_out
);
    import stse_pkg::*;

    // sequencer and working registers
    t_fsm        r_state, n_state;
    t_idx        r_idx, n_idx;
    logic        r_hit, n_hit;
    t_in_item    r_item, n_item;
    logic [31:0] r_tick, n_tick;
    logic [31:0] r_cw_start, n_cw_start;
    logic [31:0] r_cw_ticks;
    logic        r_out_valid, n_out_valid;
    t_out_item   r_out, n_out;

    // table port
    t_entry      rd_entry;
    t_entry      wr_entry;
    logic        wr_en;

    // shared compare results for the current entry
    logic             scan_hit;
    logic             exec_fire;
    logic             from_peer;
    logic [31:0]      cw_elapsed;
    logic             timed_out;
    logic [SUM_W-1:0] buf_sum;
    logic             data_fits;
    logic             read_ok;

    stse_conn_table u_table (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_addr     (r_idx),
        .i_wr_en    (wr_en),
        .i_wr_entry (wr_entry),
        .o_rd_entry (rd_entry)
    );

    // port match for segments, free entry for opens
    assign scan_hit = (r_item.func == FN_OPEN) ? !rd_entry.used :
                      (rd_entry.used && (rd_entry.bound_port == r_item.target_port));

    // per-entry checks used by the execute step
    assign from_peer  = (rd_entry.peer_node == {1'b0, r_item.src_node});
    assign cw_elapsed = r_tick - r_cw_start;
    assign timed_out  = (cw_elapsed >= r_cw_ticks);
    assign buf_sum    = SUM_W'(rd_entry.buffered) + SUM_W'(r_item.seg_length);
    assign data_fits  = (32'(r_item.seg_length) <= MAX_SEG_BYTES) &&
                        (buf_sum < SUM_W'(RECV_BUF_BYTES));
    assign read_ok    = (32'(r_item.read_length) <= 32'(rd_entry.buffered));

    assign i_in.ready  = (r_state == S_IDLE);
    assign o_out.valid = r_out_valid;
    assign o_out.item  = r_out;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // control and counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx       <= '0;
            r_hit       <= 1'b0;
            r_tick      <= 32'd0;
            r_cw_start  <= 32'd0;
            r_cw_ticks  <= CW_TICKS_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_idx       <= n_idx;
            r_hit       <= n_hit;
            r_tick      <= n_tick;
            r_cw_start  <= n_cw_start;
            r_out_valid <= n_out_valid;
            if (i_cfg_wr_en && (i_cfg_index == CFG_CLOSEWAIT_TICKS)) begin
                r_cw_ticks <= i_cfg_data;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_item <= n_item;
        r_out  <= n_out;
    end

    // next state, table update and result
    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_hit       = r_hit;
        n_item      = r_item;
        n_tick      = r_tick;
        n_cw_start  = r_cw_start;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        wr_en       = 1'b0;
        wr_entry    = rd_entry;
        exec_fire   = 1'b0;

        // result register drains on its transfer
        if (o_out.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    n_item = i_in.item;
                    n_idx  = '0;
                    n_hit  = 1'b0;
                    case (i_in.item.func)
                        FN_SEGMENT: begin
                            n_state = (i_in.item.target_port == 16'd0) ? S_EXEC : S_SCAN;
                        end
                        FN_OPEN: begin
                            n_state = S_SCAN;
                        end
                        FN_LISTEN, FN_READ, FN_CLOSE: begin
                            if (32'(i_in.item.socket_id) < CONNECTIONS) begin
                                n_idx = t_idx'(i_in.item.socket_id);
                                n_hit = 1'b1;
                            end
                            n_state = S_EXEC;
                        end
                        default: begin
                            n_state = S_EXEC;
                        end
                    endcase
                end
            end

            // one table entry per cycle
            S_SCAN: begin
                if (scan_hit) begin
                    n_hit   = 1'b1;
                    n_state = S_EXEC;
                end else if (r_idx == IDX_LAST) begin
                    n_hit   = 1'b0;
                    n_state = S_EXEC;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end

            // read-modify-write of the addressed entry, result loaded
            S_EXEC: begin
                if (!r_out_valid || o_out.ready) begin
                    exec_fire   = 1'b1;
                    n_out       = '0;
                    n_out.status = STS_OK;
                    case (r_item.func)
                        FN_SEGMENT: begin
                            n_out.status = STS_DROPPED;
                            if (r_hit) begin
                                wr_en = 1'b1;
                                n_out.result_socket = 4'(r_idx);
                                case (rd_entry.state)
                                    CS_LISTEN: begin
                                        if ((r_item.seg_kind == SK_SYN) &&
                                            ((rd_entry.peer_node == NODE_UNKNOWN) || from_peer)) begin
                                            wr_entry.state     = CS_CONN;
                                            wr_entry.peer_port = r_item.sender_port;
                                            wr_entry.peer_node = {1'b0, r_item.src_node};
                                            n_out.reply_valid  = 1'b1;
                                            n_out.reply_kind   = SK_SYNACK;
                                            n_out.status       = STS_OK;
                                        end
                                    end
                                    CS_CONN: begin
                                        if (from_peer) begin
                                            if (r_item.seg_kind == SK_SYN) begin
                                                wr_entry.peer_port = r_item.sender_port;
                                                n_out.reply_valid  = 1'b1;
                                                n_out.reply_kind   = SK_SYNACK;
                                                n_out.status       = STS_OK;
                                            end else if (r_item.seg_kind == SK_FIN) begin
                                                wr_entry.state    = CS_CWAIT;
                                                n_cw_start        = r_tick;
                                                n_out.reply_valid = 1'b1;
                                                n_out.reply_kind  = SK_FINACK;
                                                n_out.status      = STS_OK;
                                            end else if (r_item.seg_kind == SK_DATA) begin
                                                if (r_item.seq_number != rd_entry.expected_seq) begin
                                                    n_out.status = STS_OUT_OF_SEQ;
                                                end else if (!data_fits) begin
                                                    n_out.status = STS_BUFFER_FULL;
                                                end else begin
                                                    wr_entry.expected_seq = rd_entry.expected_seq +
                                                                            32'(r_item.seg_length);
                                                    wr_entry.buffered     = BUF_W'(buf_sum);
                                                    n_out.status          = STS_OK;
                                                end
                                                n_out.reply_valid = 1'b1;
                                                n_out.reply_kind  = SK_DATAACK;
                                                n_out.ack_number  = wr_entry.expected_seq;
                                            end
                                        end
                                    end
                                    CS_CWAIT: begin
                                        if (timed_out) begin
                                            wr_entry.state    = CS_CLOSED;
                                            wr_entry.buffered = '0;
                                            n_out.status      = STS_OK;
                                        end else if ((r_item.seg_kind == SK_FIN) && from_peer) begin
                                            n_out.reply_valid = 1'b1;
                                            n_out.reply_kind  = SK_FINACK;
                                            n_out.status      = STS_OK;
                                        end
                                    end
                                    default: begin
                                    end
                                endcase
                                n_out.conn_state_out = wr_entry.state;
                                if (n_out.reply_valid) begin
                                    n_out.reply_src_port  = wr_entry.bound_port;
                                    n_out.reply_dest_port = wr_entry.peer_port;
                                    n_out.reply_node      = wr_entry.peer_node[7:0];
                                end
                            end
                        end
                        FN_OPEN: begin
                            if (r_hit) begin
                                wr_en               = 1'b1;
                                wr_entry            = ENTRY_RESET;
                                wr_entry.used       = 1'b1;
                                wr_entry.bound_port = r_item.local_port;
                                n_out.result_socket = 4'(r_idx);
                            end else begin
                                n_out.status = STS_NO_FREE;
                            end
                        end
                        FN_LISTEN, FN_READ, FN_CLOSE: begin
                            if (!r_hit || !rd_entry.used) begin
                                n_out.status = STS_NOT_IN_USE;
                            end else begin
                                n_out.result_socket = 4'(r_idx);
                                if (r_item.func == FN_LISTEN) begin
                                    if (rd_entry.state != CS_CONN) begin
                                        wr_en          = 1'b1;
                                        wr_entry.state = CS_LISTEN;
                                        n_out.status   = STS_NOT_READY;
                                    end
                                end else if (r_item.func == FN_READ) begin
                                    if (read_ok) begin
                                        wr_en             = 1'b1;
                                        wr_entry.buffered = rd_entry.buffered -
                                                            BUF_W'(r_item.read_length);
                                    end else begin
                                        n_out.status = STS_NOT_READY;
                                    end
                                end else begin
                                    wr_en    = 1'b1;
                                    wr_entry = ENTRY_RESET;
                                end
                                n_out.conn_state_out = wr_entry.state;
                            end
                        end
                        FN_TICK: begin
                            n_tick = r_tick + 32'd1;
                        end
                        default: begin
                        end
                    endcase
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // checks on the sequencer and table
    `STSE_ASSERT(a_accept_leaves_idle, i_clk, i_rst_n, (i_in.valid && i_in.ready) |=> (r_state != S_IDLE), "accepted transfer did not start work")
    `STSE_ASSERT(a_result_from_exec, i_clk, i_rst_n, $rose(r_out_valid) |-> ($past(r_state) == S_EXEC), "result loaded outside the execute step")
    `STSE_ASSERT(a_scan_miss_ends, i_clk, i_rst_n, ((r_state == S_SCAN) && !scan_hit && (r_idx == IDX_LAST)) |=> ((r_state == S_EXEC) && !r_hit), "table walk ran past the last entry")
    `STSE_ASSERT(a_open_entry_in_use, i_clk, i_rst_n, (r_state == S_EXEC) |-> ((rd_entry.state == CS_CLOSED) || rd_entry.used), "entry active while not in use")
    `STSE_ASSERT(a_tick_counts, i_clk, i_rst_n, (exec_fire && (r_item.func == FN_TICK)) |=> (r_tick == ($past(r_tick) + 32'd1)), "tick did not advance the counter")

endmodule

// ===== sim/stream_transport_server_engine_unit_tb.sv =====
`timescale 1ns / 1ps
// self-checking testbench of the transport server engine: drives host operations,
// segments and ticks, predicts every result and checks it field by field
// depends on stse_pkg, stse_in_if, stse_out_if and stream_transport_server_engine_unit
module stream_transport_server_engine_unit_tb;
    import stse_pkg::*;

    localparam int TIMEOUT_NS        = 20_000_000;
    localparam int DRAIN_LIMIT       = 4000;
    localparam int SETTLE_CYCLES     = CONNECTIONS + 4;
    localparam int ITEMS_PER_SETTING = 215;

    // function codes with no operation behind them
    localparam logic [2:0] FN_SPARE_A = 3'd6;
    localparam logic [2:0] FN_SPARE_B = 3'd7;

    // register settings walked through by the traffic phases
    localparam logic [7:0]  NODE_SETTINGS [6] = '{8'h00, 8'hA5, 8'hFF, 8'h3C, 8'h81, 8'h5A};
    localparam logic [31:0] CW_SETTINGS   [6] = '{32'd3, 32'hFFFF_FFFF, 32'd0, 32'd1, 32'd7,
                                                  CW_TICKS_RESET};

    // shadow of one connection entry
    typedef struct {
        logic        used;
        t_conn_state st;
        logic [15:0] bport;
        logic [15:0] pport;
        logic [8:0]  pnode;
        logic [31:0] eseq;
        logic [31:0] nbytes;
    } t_conn;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_wr_en;
    t_cfg_idx    i_cfg_index;
    logic [31:0] i_cfg_data;

    stse_in_if  in_if ();
    stse_out_if out_if ();

    stream_transport_server_engine_unit u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in        (in_if),
        .o_out       (out_if)
    );

    // shadow state of the server
    t_conn       conn_tbl [CONNECTIONS];
    logic [31:0] tick_cnt;
    logic [31:0] cw_start;
    logic [31:0] cw_ticks;
    logic [7:0]  node_id;

    t_out_item awaited_results [$];
    int        err_cnt       = 0;
    int        sent_cnt      = 0;
    int        send_idle_pct = 20;
    int        recv_idle_pct = 69;

    // clock
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // give up after a generous fixed time
    initial begin
        #(TIMEOUT_NS);
        $display("DONE: errors detected");
        $finish;
    end

    function automatic void clear_conn(input int i);
        conn_tbl[i].used   = 1'b0;
        conn_tbl[i].st     = CS_CLOSED;
        conn_tbl[i].bport  = 16'd0;
        conn_tbl[i].pport  = 16'd0;
        conn_tbl[i].pnode  = NODE_UNKNOWN;
        conn_tbl[i].eseq   = 32'd0;
        conn_tbl[i].nbytes = 32'd0;
    endfunction

    function automatic void load_reply(inout t_out_item r, input int i, input t_seg_kind kind);
        r.reply_valid     = 1'b1;
        r.reply_kind      = kind;
        r.reply_src_port  = conn_tbl[i].bport;
        r.reply_dest_port = conn_tbl[i].pport;
        r.reply_node      = conn_tbl[i].pnode[7:0];
    endfunction

    // next state of the server and the result of one accepted transfer
    function automatic t_out_item server_step(input t_in_item it);
        t_out_item r;
        int        i;
        int        hit;
        logic      from_peer;
        r   = '0;
        hit = -1;
        case (it.func)
            FN_SEGMENT: begin
                r.status = STS_DROPPED;
                // first in-use entry bound to the destination port
                if (it.target_port != 16'd0) begin
                    for (i = 0; i < CONNECTIONS; i++) begin
                        if (hit < 0 && conn_tbl[i].used && conn_tbl[i].bport == it.target_port)
                            hit = i;
                    end
                end
                if (hit >= 0) begin
                    r.result_socket = 4'(hit);
                    from_peer = (conn_tbl[hit].pnode == {1'b0, it.src_node});
                    case (conn_tbl[hit].st)
                        CS_LISTEN: begin
                            if (it.seg_kind == SK_SYN &&
                                (conn_tbl[hit].pnode == NODE_UNKNOWN || from_peer)) begin
                                conn_tbl[hit].st    = CS_CONN;
                                conn_tbl[hit].pport = it.sender_port;
                                conn_tbl[hit].pnode = {1'b0, it.src_node};
                                load_reply(r, hit, SK_SYNACK);
                                r.status = STS_OK;
                            end
                        end
                        CS_CONN: begin
                            if (from_peer && it.seg_kind == SK_SYN) begin
                                conn_tbl[hit].pport = it.sender_port;
                                load_reply(r, hit, SK_SYNACK);
                                r.status = STS_OK;
                            end else if (from_peer && it.seg_kind == SK_FIN) begin
                                conn_tbl[hit].st = CS_CWAIT;
                                cw_start = tick_cnt;
                                load_reply(r, hit, SK_FINACK);
                                r.status = STS_OK;
                            end else if (from_peer && it.seg_kind == SK_DATA) begin
                                // in-order data must fit strictly below the buffer size
                                if (it.seq_number != conn_tbl[hit].eseq) begin
                                    r.status = STS_OUT_OF_SEQ;
                                end else if (it.seg_length > MAX_SEG_BYTES ||
                                             conn_tbl[hit].nbytes + 32'(it.seg_length) >=
                                             32'(RECV_BUF_BYTES)) begin
                                    r.status = STS_BUFFER_FULL;
                                end else begin
                                    conn_tbl[hit].eseq   += 32'(it.seg_length);
                                    conn_tbl[hit].nbytes += 32'(it.seg_length);
                                    r.status = STS_OK;
                                end
                                load_reply(r, hit, SK_DATAACK);
                                r.ack_number = conn_tbl[hit].eseq;
                            end
                        end
                        CS_CWAIT: begin
                            // any segment after the timeout closes the entry
                            if (tick_cnt - cw_start >= cw_ticks) begin
                                conn_tbl[hit].st     = CS_CLOSED;
                                conn_tbl[hit].nbytes = 32'd0;
                                r.status = STS_OK;
                            end else if (it.seg_kind == SK_FIN && from_peer) begin
                                load_reply(r, hit, SK_FINACK);
                                r.status = STS_OK;
                            end
                        end
                        default: begin
                        end
                    endcase
                    r.conn_state_out = conn_tbl[hit].st;
                end
            end
            FN_OPEN: begin
                r.status = STS_NO_FREE;
                for (i = 0; i < CONNECTIONS; i++) begin
                    if (hit < 0 && !conn_tbl[i].used)
                        hit = i;
                end
                if (hit >= 0) begin
                    clear_conn(hit);
                    conn_tbl[hit].used  = 1'b1;
                    conn_tbl[hit].bport = it.local_port;
                    r.status        = STS_OK;
                    r.result_socket = 4'(hit);
                end
            end
            FN_LISTEN, FN_READ, FN_CLOSE: begin
                i = it.socket_id;
                if (!conn_tbl[i].used) begin
                    r.status = STS_NOT_IN_USE;
                end else begin
                    r.result_socket = it.socket_id;
                    if (it.func == FN_LISTEN) begin
                        if (conn_tbl[i].st == CS_CONN) begin
                            r.status = STS_OK;
                        end else begin
                            conn_tbl[i].st = CS_LISTEN;
                            r.status = STS_NOT_READY;
                        end
                    end else if (it.func == FN_READ) begin
                        if (32'(it.read_length) <= conn_tbl[i].nbytes) begin
                            conn_tbl[i].nbytes -= 32'(it.read_length);
                            r.status = STS_OK;
                        end else begin
                            r.status = STS_NOT_READY;
                        end
                    end else begin
                        clear_conn(i);
                        r.status = STS_OK;
                    end
                    r.conn_state_out = conn_tbl[i].st;
                end
            end
            FN_TICK: begin
                tick_cnt = tick_cnt + 32'd1;
            end
            default: begin
            end
        endcase
        return r;
    endfunction

    // stimulus builders
    function automatic t_in_item rand_item();
        t_in_item it;
        it.func        = 3'($urandom_range(0, 7));
        it.seg_kind    = 3'($urandom_range(0, 7));
        it.src_node    = 8'($urandom);
        it.sender_port = 16'($urandom);
        it.target_port = 16'($urandom);
        it.seq_number  = $urandom;
        it.seg_length  = 11'($urandom);
        it.socket_id   = 4'($urandom);
        it.local_port  = 16'($urandom);
        it.read_length = 13'($urandom);
        return it;
    endfunction

    function automatic logic [15:0] pick_port();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80)
            return 16'($urandom_range(1, 10));
        else if (r < 90)
            return 16'hFFFF;
        return 16'($urandom);
    endfunction

    function automatic t_in_item make_seg(input t_seg_kind kind, input logic [7:0] node,
                                          input logic [15:0] sport, input logic [15:0] dport,
                                          input logic [31:0] seq, input logic [10:0] len);
        t_in_item it;
        it             = rand_item();
        it.func        = FN_SEGMENT;
        it.seg_kind    = kind;
        it.src_node    = node;
        it.sender_port = sport;
        it.target_port = dport;
        it.seq_number  = seq;
        it.seg_length  = len;
        return it;
    endfunction

    function automatic t_in_item make_op(input t_func f, input logic [3:0] sock,
                                         input logic [15:0] lport, input logic [12:0] rlen);
        t_in_item it;
        it             = rand_item();
        it.func        = f;
        it.socket_id   = sock;
        it.local_port  = lport;
        it.read_length = rlen;
        return it;
    endfunction

    function automatic t_in_item noise_item();
        t_in_item it;
        it = rand_item();
        if ($urandom_range(0, 1) == 0)
            it.target_port = pick_port();
        return it;
    endfunction

    // one input transfer; returns the predicted result
    task automatic send_item(input t_in_item it, output t_out_item res);
        if ($urandom_range(0, 99) < send_idle_pct) begin
            in_if.valid <= 1'b0;
            do begin
                @(posedge i_clk);
            end while ($urandom_range(0, 99) < send_idle_pct);
        end
        in_if.valid <= 1'b1;
        in_if.item  <= it;
        do begin
            @(posedge i_clk);
        end while (in_if.ready !== 1'b1);
        res = server_step(it);
        awaited_results.push_back(res);
        sent_cnt++;
    endtask

    // hold off the sender until every result is back and the block is quiet
    task automatic wait_idle();
        int n = 0;
        in_if.valid <= 1'b0;
        while (awaited_results.size() != 0 && n < DRAIN_LIMIT) begin
            @(posedge i_clk);
            n++;
        end
        if (awaited_results.size() != 0) begin
            err_cnt++;
            $display("%0t: %0d expected results never arrived", $time, awaited_results.size());
            awaited_results.delete();
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_cfg(input t_cfg_idx idx, input logic [31:0] val);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        @(posedge i_clk);
        if (idx == CFG_MY_NODE_ID)
            node_id = val[7:0];
        else
            cw_ticks = val;
    endtask

    // result side: random back-pressure
    initial begin
        out_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            out_if.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            err_cnt++;
            $display("%0t: %s expected %0h, actual %0h", $time, name, want, got);
        end
    endtask

    // compare every result transfer with the oldest prediction
    initial begin
        t_out_item want;
        forever begin
            @(posedge i_clk);
            if (out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
                if (awaited_results.size() == 0) begin
                    err_cnt++;
                    $display("%0t: result with none expected, actual %p", $time,
                             out_if.item);
                end else begin
                    want = awaited_results.pop_front();
                    check_field("status", want.status, out_if.item.status);
                    check_field("reply_valid", want.reply_valid, out_if.item.reply_valid);
                    check_field("reply_kind", want.reply_kind, out_if.item.reply_kind);
                    check_field("reply_src_port", want.reply_src_port,
                                out_if.item.reply_src_port);
                    check_field("reply_dest_port", want.reply_dest_port,
                                out_if.item.reply_dest_port);
                    check_field("reply_node", want.reply_node, out_if.item.reply_node);
                    check_field("ack_number", want.ack_number, out_if.item.ack_number);
                    check_field("result_socket", want.result_socket,
                                out_if.item.result_socket);
                    check_field("conn_state_out", want.conn_state_out,
                                out_if.item.conn_state_out);
                end
            end
        end
    end

    // bad sockets, lost segments, one full connection life and buffer limits
    task automatic test_corner_cases();
        t_out_item res;
        t_in_item  it;
        send_item(make_op(FN_READ, 4'd0, 16'd0, 13'd0), res);
        send_item(make_op(FN_LISTEN, 4'd15, 16'hFFFF, 13'h1FFF), res);
        send_item(make_op(FN_CLOSE, 4'd7, 16'd0, 13'd0), res);
        send_item(make_seg(SK_SYN, 8'hFF, 16'hFFFF, 16'd0, 32'd0, 11'd0), res);
        send_item(make_seg(SK_SYN, 8'hFF, 16'hFFFF, 16'hFFFF, 32'd0, 11'd0), res);
        send_item(make_op(FN_OPEN, 4'd0, 16'hFFFF, 13'd0), res);
        // bound but still closed
        send_item(make_seg(SK_SYN, 8'hFF, 16'hFFFF, 16'hFFFF, 32'd0, 11'd0), res);
        send_item(make_op(FN_LISTEN, 4'd0, 16'd0, 13'd0), res);
        send_item(make_seg(SK_DATA, 8'hFF, 16'hFFFF, 16'hFFFF, 32'd0, 11'd1), res);
        send_item(make_seg(SK_SYN, 8'hFF, 16'hFFFF, 16'hFFFF, 32'd0, 11'd0), res);
        send_item(make_op(FN_LISTEN, 4'd0, 16'd0, 13'd0), res);
        // foreign node, then repeated syn from the peer
        send_item(make_seg(SK_SYN, 8'h00, 16'h0000, 16'hFFFF, 32'd0, 11'd0), res);
        send_item(make_seg(SK_SYN, 8'hFF, 16'h0001, 16'hFFFF, 32'd0, 11'd0), res);
        // data: in order, out of order, too long, exact buffer size
        send_item(make_seg(SK_DATA, 8'hFF, 16'h0001, 16'hFFFF, 32'd0, 11'd1500), res);
        send_item(make_seg(SK_DATA, 8'hFF, 16'h0001, 16'hFFFF, 32'hFFFF_FFFF, 11'd1), res);
        send_item(make_seg(SK_DATA, 8'hFF, 16'h0001, 16'hFFFF, 32'd1500, 11'h7FF), res);
        send_item(make_seg(SK_DATA, 8'hFF, 16'h0001, 16'hFFFF, 32'd1500, 11'd1500), res);
        send_item(make_seg(SK_DATA, 8'hFF, 16'h0001, 16'hFFFF, 32'd3000, 11'd1096), res);
        // reads: too long, exact, empty
        send_item(make_op(FN_READ, 4'd0, 16'd0, 13'h1FFF), res);
        send_item(make_op(FN_READ, 4'd0, 16'd0, 13'd3000), res);
        send_item(make_op(FN_READ, 4'd0, 16'd0, 13'd0), res);
        send_item(make_seg(SK_FIN, 8'hFF, 16'h0001, 16'hFFFF, 32'd0, 11'd0), res);
        send_item(make_seg(SK_FIN, 8'hFF, 16'h0001, 16'hFFFF, 32'd0, 11'd0), res);
        send_item(make_op(FN_TICK, 4'd0, 16'd0, 13'd0), res);
        it = rand_item();
        it.func = FN_SPARE_A;
        send_item(it, res);
        it.func = FN_SPARE_B;
        send_item(it, res);
    endtask

    // close-wait entry closed by the next segment once the timeout is zero
    task automatic test_close_wait_timeout();
        t_out_item res;
        wait_idle();
        write_cfg(CFG_CLOSEWAIT_TICKS, 32'd0);
        send_item(make_seg(SK_DATAACK, 8'h00, 16'h0000, 16'hFFFF, 32'd0, 11'd0), res);
        send_item(make_op(FN_CLOSE, 4'd0, 16'd0, 13'd0), res);
    endtask

    // random connection lives with random content, mixed with stray transfers
    task automatic test_sessions(input int n_items);
        t_out_item   res;
        int          stop_at;
        int          sock;
        int          r;
        logic [7:0]  node;
        logic [15:0] port;
        logic [15:0] sport;
        logic [31:0] seq;
        logic [10:0] len;
        logic [12:0] rlen;
        stop_at = sent_cnt + n_items;
        while (sent_cnt < stop_at) begin
            if ($urandom_range(0, 99) < 15) begin
                send_item(noise_item(), res);
                continue;
            end
            port = pick_port();
            send_item(make_op(FN_OPEN, 4'($urandom), port, 13'($urandom)), res);
            if (res.status != STS_OK) begin
                // table full: free a few entries
                repeat ($urandom_range(1, 4))
                    send_item(make_op(FN_CLOSE, 4'($urandom), 16'($urandom), 13'($urandom)),
                              res);
                continue;
            end
            sock  = res.result_socket;
            node  = 8'($urandom);
            sport = 16'($urandom);
            send_item(make_op(FN_LISTEN, 4'(sock), 16'($urandom), 13'($urandom)), res);
            send_item(make_seg(SK_SYN, node, sport, port, $urandom, 11'($urandom)), res);
            repeat ($urandom_range(1, 10)) begin
                r = $urandom_range(0, 99);
                if (r < 55) begin
                    seq = (r < 48) ? conn_tbl[sock].eseq : $urandom;
                    len = ($urandom_range(0, 9) == 0) ? 11'($urandom)
                                                      : 11'($urandom_range(0, 600));
                    send_item(make_seg(SK_DATA, node, sport, port, seq, len), res);
                end else if (r < 75) begin
                    rlen = ($urandom_range(0, 4) == 0) ? 13'($urandom)
                         : 13'($urandom_range(0, conn_tbl[sock].nbytes));
                    send_item(make_op(FN_READ, 4'(sock), 16'($urandom), rlen), res);
                end else if (r < 82) begin
                    send_item(make_seg(SK_SYN, node, sport, port, $urandom, 11'($urandom)),
                              res);
                end else if (r < 88) begin
                    send_item(make_seg(t_seg_kind'($urandom_range(0, 7)), node ^ 8'($urandom),
                                       16'($urandom), port, $urandom, 11'($urandom)), res);
                end else if (r < 94) begin
                    send_item(make_op(FN_TICK, 4'($urandom), 16'($urandom), 13'($urandom)),
                              res);
                end else begin
                    send_item(noise_item(), res);
                end
            end
            // teardown
            if ($urandom_range(0, 9) != 0)
                send_item(make_seg(SK_FIN, node, sport, port, $urandom, 11'($urandom)), res);
            if ($urandom_range(0, 1) == 0)
                send_item(make_seg(SK_FIN, node, sport, port, $urandom, 11'($urandom)), res);
            repeat ($urandom_range(0, 6))
                send_item(make_op(FN_TICK, 4'($urandom), 16'($urandom), 13'($urandom)), res);
            send_item(make_seg(t_seg_kind'($urandom_range(0, 7)), node, sport, port, $urandom,
                               11'($urandom)), res);
            if ($urandom_range(0, 99) < 60)
                send_item(make_op(FN_CLOSE, 4'(sock), 16'($urandom), 13'($urandom)), res);
        end
    endtask

    // test sequence
    initial begin
        i_rst_n     <= 1'b0;
        i_cfg_wr_en <= 1'b0;
        i_cfg_index <= CFG_MY_NODE_ID;
        i_cfg_data  <= 32'd0;
        in_if.valid <= 1'b0;
        in_if.item  <= '0;
        for (int i = 0; i < CONNECTIONS; i++)
            clear_conn(i);
        tick_cnt = 32'd0;
        cw_start = 32'd0;
        cw_ticks = CW_TICKS_RESET;
        node_id  = 8'd0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_corner_cases();
        test_close_wait_timeout();

        // three idling patterns, two register settings each
        for (int ph = 0; ph < 3; ph++) begin
            send_idle_pct = (ph == 0) ? 20 : (ph == 1) ? 69 : 0;
            recv_idle_pct = (ph == 0) ? 69 : (ph == 1) ? 20 : 0;
            for (int s = 0; s < 2; s++) begin
                wait_idle();
                write_cfg(CFG_MY_NODE_ID, {24'd0, NODE_SETTINGS[2 * ph + s]});
                write_cfg(CFG_CLOSEWAIT_TICKS, CW_SETTINGS[2 * ph + s]);
                test_sessions(ITEMS_PER_SETTING);
            end
        end

        wait_idle();
        if (err_cnt == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
